// File: src/lmlt_pkg.sv
// Package for the LCD mode and scan-line timing block.
// Holds the mode codes, period constants and shared state/result types; no dependencies.
package lmlt_pkg;

  localparam int unsigned LINES_PER_FRAME_DEF = 153;

  localparam int unsigned AccumW = 11;
  localparam int unsigned LineW  = 8;

  typedef enum logic [1:0] {
    ModeHblank = 2'd0,
    ModeVblank = 2'd1,
    ModeOam    = 2'd2,
    ModeXfer   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CfgLyc         = 2'd0,
    CfgStatEnables = 2'd1
  } cfg_idx_e;

  localparam logic [AccumW-1:0] HblankPeriod    = 11'd207;
  localparam logic [AccumW-1:0] OamPeriod       = 11'd83;
  localparam logic [AccumW-1:0] XferPeriod      = 11'd175;
  localparam logic [AccumW-1:0] VlinePeriod     = 11'd456;
  localparam logic [AccumW-1:0] AccumMax        = 11'd2047;
  localparam logic [LineW-1:0]  FirstVblankLine = 8'd144;

  typedef struct packed {
    mode_e             mode;
    logic [AccumW-1:0] accum;
    logic [LineW-1:0]  line;
    logic              display_on;
    logic              coincidence;
  } lmlt_state_t;

  typedef struct packed {
    logic             vblank_irq;
    logic             stat_irq;
    logic             render_strobe;
    logic [LineW-1:0] render_line;
  } lmlt_pulse_t;

endpackage

// File: src/lmlt_core.sv
// Next-state and result logic for one request of the LCD timing block.
// Pure combinational; depends on lmlt_pkg.
module lmlt_core #(
  parameter int unsigned LinesPerFrame = lmlt_pkg::LINES_PER_FRAME_DEF
) (
  input  lmlt_pkg::lmlt_state_t cur_i,
  input  logic                  cmd_i,
  input  logic [7:0]            cycles_i,
  input  logic                  ime_i,
  input  logic                  lcd_enable_i,
  input  logic [7:0]            lyc_i,
  input  logic [3:0]            stat_en_i,
  output lmlt_pkg::lmlt_state_t nxt_o,
  output lmlt_pkg::lmlt_pulse_t pulse_o
);
  import lmlt_pkg::*;

  localparam logic [LineW:0] Lpf = (LineW+1)'(LinesPerFrame);

  logic [LineW:0]    line_inc;
  logic [LineW-1:0]  line_step;
  logic              step_match;
  logic [AccumW:0]   sum;
  logic [AccumW-1:0] sat;
  logic [AccumW-1:0] period;
  logic              done;
  logic [AccumW-1:0] rem;

  always_comb begin
    line_inc   = {1'b0, cur_i.line} + (LineW+1)'(1);
    line_step  = (line_inc >= Lpf) ? LineW'(line_inc - Lpf) : line_inc[LineW-1:0];
    step_match = (line_step == lyc_i);
    sum        = {1'b0, cur_i.accum} + {(AccumW-7)'(0), cycles_i};
    sat        = sum[AccumW] ? AccumMax : sum[AccumW-1:0];
    case (cur_i.mode)
      ModeHblank: period = HblankPeriod;
      ModeOam:    period = OamPeriod;
      ModeXfer:   period = XferPeriod;
      default:    period = VlinePeriod;
    endcase
    done = (sat >= period);
    rem  = sat - period;
  end

  always_comb begin
    nxt_o   = cur_i;
    pulse_o = '0;
    if (cmd_i) begin
      if (lcd_enable_i && !cur_i.display_on) begin
        nxt_o.line  = '0;
        nxt_o.accum = '0;
      end
      nxt_o.display_on = lcd_enable_i;
    end else if (cur_i.display_on) begin
      nxt_o.accum = done ? rem : sat;
      if (done) begin
        case (cur_i.mode)
          ModeHblank: begin
            if (cur_i.line < FirstVblankLine) begin
              pulse_o.render_strobe = 1'b1;
              pulse_o.render_line   = cur_i.line;
            end
            nxt_o.line        = line_step;
            nxt_o.coincidence = step_match;
            if (line_step == FirstVblankLine) begin
              nxt_o.mode         = ModeVblank;
              pulse_o.vblank_irq = 1'b1;
              pulse_o.stat_irq   = ime_i && (step_match || stat_en_i[ModeVblank]);
            end else begin
              nxt_o.mode       = ModeOam;
              pulse_o.stat_irq = ime_i && (step_match || stat_en_i[ModeOam]);
            end
          end
          ModeOam: nxt_o.mode = ModeXfer;
          ModeXfer: begin
            nxt_o.mode       = ModeHblank;
            pulse_o.stat_irq = ime_i && stat_en_i[ModeHblank];
          end
          default: begin
            nxt_o.line        = line_step;
            nxt_o.coincidence = step_match;
            pulse_o.stat_irq  = ime_i && step_match;
            if (line_step == '0) begin
              nxt_o.mode       = ModeOam;
              pulse_o.stat_irq = ime_i && (step_match || stat_en_i[ModeOam]);
            end
          end
        endcase
      end
    end
  end

endmodule

// File: src/lcd_mode_line_timing.sv
// Top level of the LCD mode and scan-line timing block.
// Input register, state and result registers; uses lmlt_pkg and lmlt_core.
//
// Usage:
//   Slave stream: one request per tick or LCDC write. tuser carries cmd
//   (0 tick, 1 LCDC write); tdata carries cycles, ime and lcd_enable.
//   Master stream: exactly one result per request with mode, line,
//   coincidence flag, interrupt pulses and the render strobe/line.
//   Config port: cfg_we_i writes lyc (index 0) or stat_enables (index 1);
//   other indexes are ignored. Write only while no request is in flight.
// Path: a request goes through the input register, then the result register.
// Throughput: one request per cycle while m_axis_tready is high; the mode/line update
//   is a single add, saturate, compare and subtract on the 11-bit accumulator.
// Reset: mode oam scan, line, accumulator, display enable, coincidence
//   and both config registers cleared; no requests held.
// Stall: when m_axis_tready is low the result register holds, the input
//   register fills, and s_axis_tready drops only once both are full.
module lcd_mode_line_timing #(
  parameter int unsigned LinesPerFrame = lmlt_pkg::LINES_PER_FRAME_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] cycles, [8] ime, [9] lcd_enable, zero pad
  input  logic        s_axis_tuser,  // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [1:0] mode, [9:2] line, [10] lyc_match,
                                     // [11] vblank_irq, [12] stat_irq,
                                     // [13] render_strobe, [21:14] render_line, zero pad
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import lmlt_pkg::*;

  logic        in_valid_q;
  logic        in_cmd_q;
  logic [7:0]  in_cycles_q;
  logic        in_ime_q;
  logic        in_en_q;
  logic        out_valid_q;
  logic [23:0] out_data_q, out_data_d;
  logic [7:0]  lyc_q;
  logic [3:0]  stat_en_q;
  lmlt_state_t state_q, state_d;
  lmlt_pulse_t pulse;
  logic        advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  lmlt_core #(
    .LinesPerFrame(LinesPerFrame)
  ) u_core (
    .cur_i       (state_q),
    .cmd_i       (in_cmd_q),
    .cycles_i    (in_cycles_q),
    .ime_i       (in_ime_q),
    .lcd_enable_i(in_en_q),
    .lyc_i       (lyc_q),
    .stat_en_i   (stat_en_q),
    .nxt_o       (state_d),
    .pulse_o     (pulse)
  );

  assign out_data_d = {2'b00, pulse.render_line, pulse.render_strobe, pulse.stat_irq,
                       pulse.vblank_irq, state_d.coincidence, state_d.line, state_d.mode};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lyc_q     <= '0;
      stat_en_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLyc:         lyc_q     <= cfg_data_i;
        CfgStatEnables: stat_en_q <= cfg_data_i[3:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: ModeOam, accum: '0, line: '0, display_on: 1'b0,
                       coincidence: 1'b0};
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q    <= s_axis_tuser;
      in_cycles_q <= s_axis_tdata[7:0];
      in_ime_q    <= s_axis_tdata[8];
      in_en_q     <= s_axis_tdata[9];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule
